### src/flash_erase_command_sequencer_defines.svh
// Assertion macros used by the checker of the erase sequencer.
// No dependencies; include by bare file name.
`ifndef FLASH_ERASE_COMMAND_SEQUENCER_DEFINES_SVH
`define FLASH_ERASE_COMMAND_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FECS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fecs check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FECS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fecs check failed");

// Next-cycle implication that also holds across reset.
`define FECS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fecs check failed");

`endif

### src/fecs_pkg.sv
// Shared types, opcodes and constants of the flash erase command sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package fecs_pkg;

    // Field widths
    localparam int FIRST_W = 24;
    localparam int END_W   = 25;
    localparam int NEXT_W  = 25;
    localparam int REMAIN_W = 26;

    // Defaults for the top-level parameters
    localparam int DEF_PAGE_SIZE    = 512;
    localparam int DEF_ADDRESS_BITS = 24;

    // Chip type codes
    localparam logic [1:0] CHIP_DATAFLASH = 2'd1;
    localparam logic [1:0] CHIP_NOR       = 2'd2;

    // Input operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_READY = 1'b1;

    // Flash command bytes
    localparam logic [7:0] CMD_WRITE_ENABLE = 8'h06;
    localparam logic [7:0] CMD_DF_BLOCK     = 8'h50;
    localparam logic [7:0] CMD_DF_PAGE      = 8'h81;
    localparam logic [7:0] CMD_NOR_SECTOR   = 8'hd8;
    localparam logic [7:0] CMD_NOR_PAGE     = 8'hdb;

    // Frame lengths in bytes
    localparam logic [2:0] LEN_WRITE_ENABLE = 3'd1;
    localparam logic [2:0] LEN_ERASE        = 3'd4;

    // Erase unit sizes and alignment masks
    localparam logic [NEXT_W-1:0] DF_BLOCK_BYTES   = 25'd4096;
    localparam logic [NEXT_W-1:0] NOR_SECTOR_BYTES = 25'd65536;
    localparam logic [NEXT_W-1:0] NOR_PAGE_BYTES   = 25'd256;
    localparam logic [NEXT_W-1:0] DF_BLOCK_MASK    = 25'h000e00;
    localparam logic [NEXT_W-1:0] NOR_SECTOR_MASK  = 25'h00ff00;

    // Output frame queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Configuration register map
    localparam int PADDR_W = 3;
    localparam logic REG_CHIP_TYPE = 1'b0;

    // One frame sent toward the flash
    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] addr_byte1;
        logic [7:0] addr_byte2;
        logic [7:0] addr_byte3;
        logic [2:0] frame_bytes;
        logic       range_complete;
        logic       last;
    } frame_t;

    // Frames produced by one input item
    typedef struct packed {
        logic [1:0] count;
        frame_t     first;
        frame_t     second;
    } push_t;

    // One accepted input item
    typedef struct packed {
        logic               operation;
        logic [FIRST_W-1:0] first_address;
        logic [END_W-1:0]   end_address;
    } item_t;

endpackage

### src/fecs_cfg.sv
// APB-style configuration register file holding the chip type.
// Depends on fecs_pkg.
`timescale 1ns / 1ps

module fecs_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fecs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [1:0]                  chip_type
);

    logic [1:0] chip_type_reg;
    logic [1:0] chip_type_next;
    logic       reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register write decode.
    always_comb begin
        chip_type_next = chip_type_reg;
        if (wr_en) begin
            unique case (reg_idx)
                fecs_pkg::REG_CHIP_TYPE: chip_type_next = pwdata[1:0];
                default:                 chip_type_next = chip_type_reg;
            endcase
        end
    end

    // Read back.
    always_comb begin
        unique case (reg_idx)
            fecs_pkg::REG_CHIP_TYPE: prdata = {30'd0, chip_type_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chip_type_reg <= 2'd0;
        end else begin
            chip_type_reg <= chip_type_next;
        end
    end

    assign chip_type = chip_type_reg;

endmodule

### src/fecs_step.sv
// Input register, range state and single-pass step logic of the sequencer.
// Depends on fecs_pkg; feeds frames into fecs_queue.
`timescale 1ns / 1ps

module fecs_step #(
    parameter int PAGE_SIZE    = fecs_pkg::DEF_PAGE_SIZE,
    parameter int ADDRESS_BITS = fecs_pkg::DEF_ADDRESS_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  fecs_pkg::item_t     in_item,
    input  logic [1:0]          chip_type,
    input  logic                queue_room,
    output fecs_pkg::push_t     push
);

    localparam int NW = fecs_pkg::NEXT_W;
    localparam int FW = fecs_pkg::FIRST_W;
    localparam int RW = fecs_pkg::REMAIN_W;
    localparam logic [NW-1:0] LIM       = NW'(1) << ADDRESS_BITS;
    localparam logic [NW-1:0] ADDR_MASK = LIM - NW'(1);
    localparam logic [FW-1:0] PMASK     = FW'(PAGE_SIZE - 1);
    localparam logic [NW-1:0] PAGE_INC  = NW'(PAGE_SIZE);
    localparam logic [RW-1:0] PAGE_RW   = RW'(PAGE_SIZE);

    logic              in_valid_reg;
    logic              op_reg;
    logic [FW-1:0]     start_begin_reg;
    logic [FW-1:0]     start_stop_reg;
    logic [NW-1:0]     next_addr_reg;
    logic [NW-1:0]     next_addr_next;
    logic [FW-1:0]     stop_addr_reg;
    logic [FW-1:0]     stop_addr_next;
    logic              busy_reg;
    logic              busy_next;
    logic              consume;

    logic [FW-1:0]     first_w;
    logic [NW-1:0]     end_sat;
    logic [NW-1:0]     end_m1;
    logic [FW-1:0]     stop_pick;
    logic [FW-1:0]     start_stop;
    logic [FW-1:0]     start_begin;
    logic              is_start;
    logic              known_chip;
    logic [NW-1:0]     cur_a;
    logic [FW-1:0]     cur_stop;
    logic [RW-1:0]     remain;
    logic              big;
    logic [NW-1:0]     step_next;
    logic              done;
    fecs_pkg::frame_t  erase_f;
    fecs_pkg::frame_t  wren_f;

    // Page alignment of a new range, done before the input register. An empty
    // or reversed range keeps the page of the first address; the end is
    // clamped to the device size.
    assign first_w     = in_item.first_address & ADDR_MASK[FW-1:0];
    assign end_sat     = (in_item.end_address > LIM) ? LIM : in_item.end_address;
    assign end_m1      = end_sat - NW'(1);
    assign stop_pick   = (end_sat <= {1'b0, first_w}) ? first_w : end_m1[FW-1:0];
    assign start_stop  = stop_pick | PMASK;
    assign start_begin = first_w & ~PMASK;

    // Input register: a new transfer enters when none is held or the held item moves on.
    assign consume  = in_valid_reg && queue_room;
    assign in_ready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            op_reg          <= in_item.operation;
            start_begin_reg <= start_begin;
            start_stop_reg  <= start_stop;
        end
    end

    assign is_start   = (op_reg == fecs_pkg::OP_START);
    assign known_chip = (chip_type == fecs_pkg::CHIP_DATAFLASH) ||
                        (chip_type == fecs_pkg::CHIP_NOR);

    // Address and bound of the step taken now.
    assign cur_a    = is_start ? {1'b0, start_begin_reg} : next_addr_reg;
    assign cur_stop = is_start ? start_stop_reg : stop_addr_reg;
    assign remain   = {2'b00, cur_stop} + PAGE_RW - {1'b0, cur_a};

    // Pick the erase size and build the erase frame.
    always_comb begin
        erase_f                = '0;
        erase_f.frame_bytes    = fecs_pkg::LEN_ERASE;
        erase_f.last           = 1'b1;
        big                    = 1'b0;
        step_next              = cur_a;
        if (chip_type == fecs_pkg::CHIP_NOR) begin
            big = ((cur_a & fecs_pkg::NOR_SECTOR_MASK) == '0) &&
                  (remain >= RW'(fecs_pkg::NOR_SECTOR_BYTES));
            step_next = cur_a + (big ? fecs_pkg::NOR_SECTOR_BYTES
                                     : fecs_pkg::NOR_PAGE_BYTES);
            erase_f.opcode     = big ? fecs_pkg::CMD_NOR_SECTOR : fecs_pkg::CMD_NOR_PAGE;
            erase_f.addr_byte1 = cur_a[23:16];
            erase_f.addr_byte2 = cur_a[15:8];
            erase_f.addr_byte3 = cur_a[7:0];
        end else begin
            big = ((cur_a & fecs_pkg::DF_BLOCK_MASK) == '0) &&
                  (remain >= RW'(fecs_pkg::DF_BLOCK_BYTES));
            step_next = cur_a + (big ? fecs_pkg::DF_BLOCK_BYTES : PAGE_INC);
            erase_f.opcode     = big ? fecs_pkg::CMD_DF_BLOCK : fecs_pkg::CMD_DF_PAGE;
            erase_f.addr_byte1 = cur_a[22:15];
            erase_f.addr_byte2 = cur_a[14:7];
            erase_f.addr_byte3 = 8'd0;
        end
        done                   = (step_next > {1'b0, cur_stop});
        erase_f.range_complete = done;
    end

    // The write-enable frame that opens every serial NOR erase.
    always_comb begin
        wren_f             = '0;
        wren_f.opcode      = fecs_pkg::CMD_WRITE_ENABLE;
        wren_f.frame_bytes = fecs_pkg::LEN_WRITE_ENABLE;
    end

    // Frames for the queue and the next range state.
    always_comb begin
        push           = '0;
        next_addr_next = next_addr_reg;
        stop_addr_next = stop_addr_reg;
        busy_next      = busy_reg;
        if (consume && (is_start || busy_reg)) begin
            if (!known_chip) begin
                busy_next = 1'b0;
            end else begin
                next_addr_next = step_next;
                stop_addr_next = cur_stop;
                busy_next      = !done;
                if (chip_type == fecs_pkg::CHIP_NOR) begin
                    push.count  = 2'd2;
                    push.first  = wren_f;
                    push.second = erase_f;
                end else begin
                    push.count = 2'd1;
                    push.first = erase_f;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_addr_reg <= '0;
            stop_addr_reg <= '0;
            busy_reg      <= 1'b0;
        end else begin
            next_addr_reg <= next_addr_next;
            stop_addr_reg <= stop_addr_next;
            busy_reg      <= busy_next;
        end
    end

endmodule

### src/fecs_queue.sv
// Four-entry frame queue that takes up to two frames per cycle and sends one while its output is ready.
// Depends on fecs_pkg.
`timescale 1ns / 1ps

module fecs_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  fecs_pkg::push_t  push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output fecs_pkg::frame_t out_frame
);

    localparam int PW = fecs_pkg::QPTR_W;
    localparam int CW = fecs_pkg::QCNT_W;

    fecs_pkg::frame_t entry_reg [fecs_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [PW-1:0]    wr_ptr_plus1;
    logic             pop;

    // Room for a full two-frame push, judged on the registered count.
    assign room      = (count_reg <= CW'(fecs_pkg::QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_frame = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    assign wr_ptr_plus1 = wr_ptr_reg + PW'(1);

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Frame storage.
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

### src/flash_erase_command_sequencer.sv
// Channel    Dir  Ports                     Contents
// s_         in   tvalid tready tdata tuser  start range or device-ready transfer
// m_         out  tvalid tready tdata tuser  one flash command frame per transfer
// apb        in   psel penable pwrite ...    chip type register at address 0
//
// An input transfer is page-aligned on its way into the input register; from
// there, once the queue has room, the step logic reads the range state and
// writes its frames into a four-entry queue, whose head is offered on the frame
// port. Dataflash steps take one item per cycle while the output is ready;
// serial NOR steps emit two frames each, so for them the output port sets the
// pace. Reset (aresetn low, synchronous) clears the queue, the range state and
// the chip type. A stalled output holds its frame; input is still taken while
// the queue has room for two frames.
// Depends on fecs_pkg, fecs_cfg, fecs_step and fecs_queue.
`timescale 1ns / 1ps

module flash_erase_command_sequencer #(
    parameter int PAGE_SIZE    = fecs_pkg::DEF_PAGE_SIZE,
    parameter int ADDRESS_BITS = fecs_pkg::DEF_ADDRESS_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [55:0]                  s_tdata,  // first_address, end_address, pad
    input  logic [0:0]                   s_tuser,  // operation
    // Frame stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,  // opcode, addr_byte1, addr_byte2, addr_byte3
    output logic [3:0]                   m_tuser,  // frame_bytes[2:0], range_complete[3]
    output logic                         m_tlast,
    // Configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fecs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    fecs_pkg::item_t  in_item;
    fecs_pkg::push_t  push;
    fecs_pkg::frame_t out_frame;
    logic [1:0]       chip_type;
    logic             queue_room;

    // Unpack the input transfer.
    assign in_item.operation     = s_tuser[0];
    assign in_item.first_address = s_tdata[23:0];
    assign in_item.end_address   = s_tdata[48:24];

    fecs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .chip_type (chip_type)
    );

    fecs_step #(
        .PAGE_SIZE    (PAGE_SIZE),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .chip_type  (chip_type),
        .queue_room (queue_room),
        .push       (push)
    );

    fecs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (queue_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_frame (out_frame)
    );

    // Pack the outgoing frame.
    assign m_tdata = {out_frame.addr_byte3, out_frame.addr_byte2,
                      out_frame.addr_byte1, out_frame.opcode};
    assign m_tuser = {out_frame.range_complete, out_frame.frame_bytes};
    assign m_tlast = out_frame.last;

endmodule

### src/fecs_checker.sv
// Port-level checks of the erase sequencer, bound to the top level.
// Depends on fecs_pkg and flash_erase_command_sequencer_defines.svh.
`timescale 1ns / 1ps
`include "flash_erase_command_sequencer_defines.svh"

module fecs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    logic        out_stall;
    logic [36:0] out_beat;
    logic        out_wren;
    logic        out_wren_ok;
    logic        out_done;
    logic        out_done_ok;

    // Views of the frame port used by the checks below.
    assign out_stall   = m_tvalid && !m_tready;
    assign out_beat    = {m_tlast, m_tuser, m_tdata};
    assign out_wren    = m_tvalid && (m_tdata[7:0] == fecs_pkg::CMD_WRITE_ENABLE);
    assign out_wren_ok = !m_tlast && !m_tuser[3] &&
                         (m_tuser[2:0] == fecs_pkg::LEN_WRITE_ENABLE);
    assign out_done    = m_tvalid && m_tuser[3];
    assign out_done_ok = m_tlast && (m_tuser[2:0] == fecs_pkg::LEN_ERASE);

    // A stalled frame stays put until it is taken.
    `FECS_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable(out_beat))

    // A write-enable frame is one byte long, does not complete a range and does not end the burst.
    `FECS_ASSERT_NOW(a_wren_shape, aclk, aresetn, out_wren, out_wren_ok)

    // The frame that completes a range ends the burst of its step.
    `FECS_ASSERT_NOW(a_done_last, aclk, aresetn, out_done, out_done_ok)

    // Nothing is offered right after reset.
    `FECS_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_tvalid)

endmodule

bind flash_erase_command_sequencer fecs_checker u_fecs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
